[src/knob_button_event_classifier_defines.svh]
// Assertion macros shared by the knob and button event classifier.
`ifndef KNOB_BUTTON_EVENT_CLASSIFIER_DEFINES_SVH
`define KNOB_BUTTON_EVENT_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define KBEC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define KBEC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/kbec_pkg.sv]
// Types and constants of the knob and button event classifier.
`default_nettype none

package kbec_pkg;

	localparam int unsigned TIME_W = 32;
	localparam int unsigned CFG_W  = 16;
	localparam int unsigned DIR_W  = 2;
	localparam int unsigned IDX_W  = 2;

	// Configuration register indexes
	localparam logic [IDX_W-1:0] REG_ENABLE          = 2'd0;
	localparam logic [IDX_W-1:0] REG_ROTARY_INTERVAL = 2'd1;
	localparam logic [IDX_W-1:0] REG_DEBOUNCE        = 2'd2;
	localparam logic [IDX_W-1:0] REG_LONG_PRESS      = 2'd3;

	// Decoder report codes
	localparam logic [DIR_W-1:0] DIR_CW  = 2'd1;
	localparam logic [DIR_W-1:0] DIR_CCW = 2'd2;

	typedef enum logic [2:0] {
		EV_NONE  = 3'd0,
		EV_RIGHT = 3'd1,
		EV_LEFT  = 3'd2,
		EV_SHORT = 3'd3,
		EV_LONG  = 3'd4
	} event_code_t;

	typedef struct packed {
		logic              enable;
		logic [CFG_W-1:0]  rotary_interval_ms;
		logic [CFG_W-1:0]  debounce_ms;
		logic [CFG_W-1:0]  long_press_ms;
	} cfg_t;

	typedef struct packed {
		logic              button_level;
		logic [DIR_W-1:0]  rotary_dir;
		logic [TIME_W-1:0] now_ms;
	} poll_t;

	typedef struct packed {
		event_code_t event_code;
		logic        event_found;
	} result_t;

endpackage

`default_nettype wire

[src/kbec_cfg.sv]
// Configuration register file of the knob and button event classifier.
`default_nettype none

module kbec_cfg (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_wen,
	input  wire logic [kbec_pkg::IDX_W-1:0]     cfg_index,
	input  wire logic [kbec_pkg::CFG_W-1:0]     cfg_wdata,
	output kbec_pkg::cfg_t                      cfg
);

	kbec_pkg::cfg_t cfg_q;

	// Write the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enable             <= 1'b0;
			cfg_q.rotary_interval_ms <= 16'd1;
			cfg_q.debounce_ms        <= 16'd20;
			cfg_q.long_press_ms      <= 16'd1000;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				kbec_pkg::REG_ENABLE:          cfg_q.enable             <= cfg_wdata[0];
				kbec_pkg::REG_ROTARY_INTERVAL: cfg_q.rotary_interval_ms <= cfg_wdata;
				kbec_pkg::REG_DEBOUNCE:        cfg_q.debounce_ms        <= cfg_wdata;
				kbec_pkg::REG_LONG_PRESS:      cfg_q.long_press_ms      <= cfg_wdata;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

[src/kbec_core.sv]
// Event classification: rotary rate limit, button debounce and press timing.
`default_nettype none

module kbec_core (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      step,
	input  wire kbec_pkg::cfg_t cfg,
	input  wire kbec_pkg::poll_t poll,
	output kbec_pkg::result_t result,
	output logic           first_event_pending
);

	logic [kbec_pkg::TIME_W-1:0] last_rot_q;
	logic [kbec_pkg::TIME_W-1:0] deb_start_q;
	logic [kbec_pkg::TIME_W-1:0] press_start_q;
	logic                        stable_level_q;
	logic                        deb_active_q;
	logic                        first_pending_q;

	logic [kbec_pkg::TIME_W-1:0] rot_diff;
	logic [kbec_pkg::TIME_W-1:0] deb_diff;
	logic [kbec_pkg::TIME_W-1:0] held_diff;
	logic                        rot_due;
	logic                        rot_found;
	logic                        deb_done;
	logic                        btn_eval;
	logic                        is_press;
	logic                        is_release;
	logic                        deb_start;
	logic                        raw_found;
	logic                        swallow;
	kbec_pkg::event_code_t       raw_code;

	// Elapsed times, modulo 2^32
	always_comb begin
		rot_diff  = poll.now_ms - last_rot_q;
		deb_diff  = poll.now_ms - deb_start_q;
		held_diff = poll.now_ms - press_start_q;
	end

	// Classify the poll
	always_comb begin
		rot_due   = rot_diff > {16'd0, cfg.rotary_interval_ms};
		rot_found = rot_due && (poll.rotary_dir == kbec_pkg::DIR_CW ||
		                        poll.rotary_dir == kbec_pkg::DIR_CCW);
		deb_start = !rot_found && !deb_active_q && (poll.button_level != stable_level_q);
		deb_done  = deb_diff > {16'd0, cfg.debounce_ms};
		btn_eval  = !rot_found && deb_active_q && deb_done;
		is_press  = btn_eval && stable_level_q && !poll.button_level;
		is_release = btn_eval && !stable_level_q && poll.button_level;
		raw_found = rot_found || is_release;

		priority if (rot_found && poll.rotary_dir == kbec_pkg::DIR_CW) begin
			raw_code = kbec_pkg::EV_RIGHT;
		end else if (rot_found) begin
			raw_code = kbec_pkg::EV_LEFT;
		end else if (held_diff > {16'd0, cfg.long_press_ms}) begin
			raw_code = kbec_pkg::EV_LONG;
		end else begin
			raw_code = kbec_pkg::EV_SHORT;
		end

		swallow = raw_found && first_pending_q;

		result.event_found = cfg.enable && raw_found && !swallow;
		result.event_code  = result.event_found ? raw_code : kbec_pkg::EV_NONE;
	end

	// Update state once per transfer while enabled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_rot_q      <= '0;
			deb_start_q     <= '0;
			press_start_q   <= '0;
			stable_level_q  <= 1'b0;
			deb_active_q    <= 1'b0;
			first_pending_q <= 1'b1;
		end else if (step && cfg.enable) begin
			if (rot_due) begin
				last_rot_q <= poll.now_ms;
			end
			if (deb_start) begin
				deb_active_q <= 1'b1;
				deb_start_q  <= poll.now_ms;
			end
			if (btn_eval) begin
				deb_active_q   <= 1'b0;
				stable_level_q <= poll.button_level;
			end
			if (is_press) begin
				press_start_q <= poll.now_ms;
			end
			if (swallow) begin
				first_pending_q <= 1'b0;
			end
		end
	end

	assign first_event_pending = first_pending_q;

endmodule

`default_nettype wire

[src/knob_button_event_classifier.sv]
// Knob and button event classifier: one poll in, one event result out per
// transfer. A poll is registered, classified by a single pass of compare logic
// that also updates the debounce and timing state, and the result is held in an
// output register. One poll is taken every clock cycle, and the only thing that
// slows the block is backpressure on the result side. Configuration is written
// through a plain write port; the user must write it only while the block is
// idle, as the block does not enforce this. With enable low every poll returns
// "no event" and leaves the state untouched.
`default_nettype none
`include "knob_button_event_classifier_defines.svh"

module knob_button_event_classifier (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// Poll stream
	input  wire logic                       s_tvalid,
	output logic                            s_tready,
	input  wire logic [39:0]                s_tdata,  // now_ms[31:0], rotary_dir[33:32], button_level[34], zero pad
	// Result stream
	output logic                            m_tvalid,
	input  wire logic                       m_tready,
	output logic [7:0]                      m_tdata,  // event_found[0], event_code[3:1], zero pad
	// Configuration
	input  wire logic                       cfg_wen,
	input  wire logic [kbec_pkg::IDX_W-1:0] cfg_index,
	input  wire logic [kbec_pkg::CFG_W-1:0] cfg_wdata
);

	kbec_pkg::cfg_t    cfg;
	kbec_pkg::poll_t   poll_s1;
	logic              valid_s1;
	kbec_pkg::result_t result;
	kbec_pkg::result_t result_q;
	logic              out_valid_q;
	logic              advance;
	logic              first_event_pending;

	kbec_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// Move a poll into the result register when the result slot frees up
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			poll_s1 <= s_tdata[34:0];
		end
	end

	kbec_core u_core (
		.clk                 (clk),
		.arst_n              (arst_n),
		.step                (advance),
		.cfg                 (cfg),
		.poll                (poll_s1),
		.result              (result),
		.first_event_pending (first_event_pending)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, result_q};

	// Checks
	`KBEC_ASSERT_SAME(a_none_code, clk, arst_n, m_tvalid && !m_tdata[0],
		m_tdata[3:1] == kbec_pkg::EV_NONE, "event code set without an event")
	`KBEC_ASSERT_SAME(a_first_swallowed, clk, arst_n, m_tvalid && m_tdata[0],
		!first_event_pending, "event delivered before the first one was dropped")
	`KBEC_ASSERT_NEXT(a_disabled_quiet, clk, arst_n, advance && !cfg.enable,
		m_tvalid && m_tdata[3:0] == 4'd0, "event produced while disabled")
	`KBEC_ASSERT_NEXT(a_poll_held, clk, arst_n, valid_s1 && !advance,
		valid_s1 && $stable(poll_s1), "registered poll lost while stalled")

endmodule

`default_nettype wire
